@@ rtl/spq_pkg.sv @@
// ============================================================================
// spq_pkg - shared types and constants for the sorted priority queue
// Entry layout, item kinds, result status codes and default capacity.
// ============================================================================
`default_nettype none

package spq_pkg;

    localparam int DATA_W       = 32;
    localparam int OCC_W        = 4;
    localparam int CAPACITY_DEF = 8;

    // Item kind carried on the input tuser
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Result status carried on the output tuser
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // One stored entry
    typedef struct packed {
        logic signed [DATA_W-1:0] prio;
        logic signed [DATA_W-1:0] value;
    } entry_t;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t item;
    } cell_cmd_t;

endpackage : spq_pkg

`default_nettype wire

@@ rtl/spq_cell.sv @@
// ============================================================================
// spq_cell - one slot of the sorted entry chain
// Holds one entry; on insert it keeps, takes the new entry or takes its
// upstream neighbor's entry; on remove it takes its downstream neighbor's.
// ============================================================================
`default_nettype none

module spq_cell (
    input  wire logic               clk,
    input  wire spq_pkg::cell_cmd_t cmd,
    input  wire logic               occupied,    // slot index below entry count
    input  wire logic               prev_ge,     // upstream slot stays ahead
    input  wire spq_pkg::entry_t    prev_entry,
    input  wire spq_pkg::entry_t    next_entry,
    output logic                    ge,          // this slot stays ahead
    output spq_pkg::entry_t         entry
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Held entry ranks at or above the new one
    assign ge = occupied && ($signed(entry_reg.prio) >= $signed(cmd.item.prio));

    // Next content of the slot
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert)
        begin
            if (!ge)
            begin
                entry_next = prev_ge ? cmd.item : prev_entry;
            end
        end
        else if (cmd.remove)
        begin
            entry_next = next_entry;
        end
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule : spq_cell

`default_nettype wire

@@ rtl/sorted_priority_queue.sv @@
// ============================================================================
// sorted_priority_queue - bounded priority queue in a chain of sorted cells
// Insert places an entry behind all of equal or higher priority; remove
// returns the front entry. One result per item with the entry count.
// ============================================================================
//
//  channel | dir | tdata (low bit up)                      | tuser
//  --------+-----+-----------------------------------------+--------------
//  s_*     | in  | item_value[31:0], item_priority[63:32]  | kind
//  m_*     | out | out_value, out_priority, occupancy, pad | status[1:0]
//
// Items follow back to back while s_tready is high; all cells compare and
// shift in the same cycle, so cell compare plus shift mux sets the clock path.
// A result sits in an output register in the cycle after its item is accepted.
// s_tready stays high while the output register is empty or being taken.
// Reset clears the entry count and the output valid; no clearing pass.
// ============================================================================
`default_nettype none

module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // item_value[31:0], item_priority[63:32]
    input  wire logic        s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // out_value[31:0], out_priority[63:32],
                                        // occupancy[67:64], zero[71:68]
    output logic [1:0]       m_tuser    // status
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic           accept;
    logic           is_remove;
    logic           full;
    logic           empty;
    logic           do_ins;
    logic           do_rem;
    cell_cmd_t      cmd;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    status_t        status;

    entry_t         cell_q  [CAPACITY];
    logic           cell_ge [CAPACITY];
    logic           cell_occ[CAPACITY];

    logic           out_valid_reg;
    status_t        out_status_reg;
    entry_t         out_entry_reg;
    logic [OCC_W-1:0] out_occ_reg;

    // Input handshake and item decode
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign is_remove = (s_tuser == KIND_REMOVE);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign do_ins    = accept && !is_remove && !full;
    assign do_rem    = accept && is_remove && !empty;

    assign cmd.insert     = do_ins;
    assign cmd.remove     = do_rem;
    assign cmd.item.value = s_tdata[31:0];
    assign cmd.item.prio  = s_tdata[63:32];

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        logic   prev_g;

        assign cell_occ[i] = (count_reg > CW'(i));

        if (i == 0)
        begin : g_head
            assign prev_e = cmd.item;
            assign prev_g = 1'b1;
        end
        else
        begin : g_body
            assign prev_e = cell_q[i-1];
            assign prev_g = cell_ge[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_e = cmd.item;
        end
        else
        begin : g_inner
            assign next_e = cell_q[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .occupied   (cell_occ[i]),
            .prev_ge    (prev_g),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .ge         (cell_ge[i]),
            .entry      (cell_q[i])
        );
    end

    // Entry count and result status
    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rem)
        begin
            count_next = count_reg - CW'(1);
        end

        if (is_remove)
        begin
            status = empty ? ST_EMPTY : ST_REMOVED;
        end
        else
        begin
            status = full ? ST_FULL : ST_INSERTED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (s_tready)
            begin
                out_valid_reg <= s_tvalid;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_status_reg <= status;
            out_entry_reg  <= do_rem ? cell_q[0] : '0;
            out_occ_reg    <= OCC_W'(count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'b0000, out_occ_reg, out_entry_reg.prio, out_entry_reg.value};

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_remove && empty) |=> (m_tuser == ST_EMPTY))
        else $error("remove on empty queue not flagged");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow count");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_REMOVED) |-> (m_tdata[63:0] == 64'd0))
        else $error("payload not zero on non-remove result");

endmodule : sorted_priority_queue

`default_nettype wire
